FILE: hdl/hpw_pkg.sv
// ----------------------------------------------------------------------------
// hpw_pkg - shared constants, types and tables for the hemicube weighting
// Face geometry, fixed-point widths, the reciprocal constants for the
// angle division and the quarter-wave cosine table.
// ----------------------------------------------------------------------------
`default_nettype none

package hpw_pkg;

  // Frame geometry (the hemicube faces are cut from this frame)
  localparam int FRAME_WIDTH  = 512;
  localparam int FRAME_HEIGHT = 512;

  localparam int FW2 = FRAME_WIDTH / 2;
  localparam int FW4 = FRAME_WIDTH / 4;
  localparam int FH2 = FRAME_HEIGHT / 2;
  localparam int FH4 = FRAME_HEIGHT / 4;
  localparam int DIM_MAX = (FW2 > FH2) ? FW2 : FH2;

  // Widths
  localparam int BYTE_W  = 8;
  localparam int SUM_W   = 24;
  localparam int CNT_W   = 8;
  localparam int FACE_W  = 3;
  localparam int DIM_W   = $clog2(DIM_MAX) + 1;
  localparam int MW      = DIM_W + 4;               // signed half-pixel offsets
  localparam int AM_W    = $clog2(2 * DIM_MAX);     // magnitude of an offset
  localparam int NLANES  = 4;                       // cam x, cam y, patch x, patch y

  // Lane order
  localparam int LANE_CX = 0;
  localparam int LANE_CY = 1;
  localparam int LANE_PX = 2;
  localparam int LANE_PY = 3;

  // Degrees per half pixel scaled to 1/64 degree: P * 32
  localparam int PK90 = 90 * 32;
  localparam int PK45 = 45 * 32;

  // Angle division: num / f by reciprocal, exact for num < 2^NUM_W, f < 2^DIV_W
  localparam int NUM_W     = $clog2(2 * DIM_MAX * PK90) + 1;
  localparam int DIV_W     = $clog2(DIM_MAX) + 1;
  localparam int RCP_SHIFT = NUM_W + DIV_W;
  localparam int RCP_W     = RCP_SHIFT;
  localparam int PROD_W    = NUM_W + RCP_W;
  localparam int Q_W       = 15;

  localparam logic [RCP_W-1:0] RCP_FW2 =
    RCP_W'(((64'd1 << RCP_SHIFT) + 64'(FW2) - 64'd1) / 64'(FW2));
  localparam logic [RCP_W-1:0] RCP_FW4 =
    RCP_W'(((64'd1 << RCP_SHIFT) + 64'(FW4) - 64'd1) / 64'(FW4));
  localparam logic [RCP_W-1:0] RCP_FH2 =
    RCP_W'(((64'd1 << RCP_SHIFT) + 64'(FH2) - 64'd1) / 64'(FH2));
  localparam logic [RCP_W-1:0] RCP_FH4 =
    RCP_W'(((64'd1 << RCP_SHIFT) + 64'(FH4) - 64'd1) / 64'(FH4));

  localparam logic [NUM_W-1:0] HALF_FW2 = NUM_W'(FW2 / 2);
  localparam logic [NUM_W-1:0] HALF_FW4 = NUM_W'(FW4 / 2);
  localparam logic [NUM_W-1:0] HALF_FH2 = NUM_W'(FH2 / 2);
  localparam logic [NUM_W-1:0] HALF_FH4 = NUM_W'(FH4 / 2);
  localparam logic [NUM_W-1:0] PK90_N   = NUM_W'(PK90);
  localparam logic [NUM_W-1:0] PK45_N   = NUM_W'(PK45);

  // Angles in 1/64 degree, clamped at 90 degrees
  localparam int ANG_W   = 13;
  localparam int ANG_MAX = 90 * 64;

  // Cosine, Q1.15
  localparam int COS_W    = 16;
  localparam int FRAC     = 15;
  localparam int TAB_LAST = 90;
  localparam int TAB_IW   = 7;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  // Queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Face codes
  typedef enum logic [FACE_W-1:0] {
    FACE_FRONT  = 3'd0,
    FACE_TOP    = 3'd1,
    FACE_LEFT   = 3'd2,
    FACE_RIGHT  = 3'd3,
    FACE_BOTTOM = 3'd4
  } face_t;

  // Pixel bytes plus the end-of-face mark, carried down the back pipeline
  typedef struct packed {
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic              done;
  } hpw_pix_t;

  // Request classified by the front, queued for the back
  typedef struct packed {
    hpw_pix_t                      pix;
    logic [NLANES-1:0][AM_W-1:0]   am;      // |m| per lane
    logic                          x_side;  // yaw: P=45, f=FW4
    logic                          y_side;  // pitch: P=45, f=FH4
  } hpw_item_t;

  typedef logic [COS_W-1:0] cos_tab_t [0:TAB_LAST];

  // Quarter-wave table, round(32768*cos(k deg)) from a Q30 Taylor series
  function automatic cos_tab_t build_cos_tab();
    cos_tab_t    tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] v;
    longint      acc;
    for (int k = 0; k <= TAB_LAST; k++) begin
      x    = (64'(k) * PI_Q30) / 64'd180;
      x2   = (x * x) >> 30;
      term = 64'd1 << 30;
      acc  = longint'(term);
      for (int n = 1; n <= 12; n++) begin
        term = (term * x2) >> 30;
        term = term / 64'((2 * n - 1) * (2 * n));
        if ((n % 2) == 1) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      v = (64'(acc) + 64'd16384) >> 15;
      if (v > 64'd32768) begin
        v = 64'd32768;
      end
      tab[k] = COS_W'(v);
    end
    return tab;
  endfunction

  localparam cos_tab_t COS_TAB = build_cos_tab();

endpackage

`default_nettype wire

FILE: hdl/hpw_if.sv
// ----------------------------------------------------------------------------
// hpw_if - valid/ready channels of the hemicube weighting block
// Pixel input, weighted result and face_select configuration channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface hpw_in_if;
  import hpw_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] red_in;
  logic [BYTE_W-1:0] green_in;
  logic [BYTE_W-1:0] blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in,
                  output ready);
endinterface

interface hpw_out_if;
  import hpw_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] red_out;
  logic [BYTE_W-1:0] green_out;
  logic [BYTE_W-1:0] blue_out;
  logic              face_done;
  logic [SUM_W-1:0]  red_total;
  logic [SUM_W-1:0]  green_total;
  logic [SUM_W-1:0]  blue_total;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output face_done, output red_total, output green_total,
                  output blue_total, input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  input face_done, input red_total, input green_total,
                  input blue_total, output ready);
endinterface

interface hpw_cfg_if;
  import hpw_pkg::*;
  logic              valid;
  logic              ready;
  logic [FACE_W-1:0] face_select;

  modport source (output valid, output face_select, input ready);
  modport sink   (input valid, input face_select, output ready);
endinterface

`default_nettype wire

FILE: hdl/hpw_front.sv
// ----------------------------------------------------------------------------
// hpw_front - pixel intake and classification
// Holds face_select, tracks column and row, and turns them into the four
// half-pixel offsets and the face geometry flags queued for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module hpw_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  hpw_in_if.sink                 in_ch,
  hpw_cfg_if.sink                cfg_ch,
  input  wire logic              q_full,
  output      logic              q_push,
  output      hpw_pkg::hpw_item_t q_item,
  output      logic              cfg_clr
);
  import hpw_pkg::*;

  logic [FACE_W-1:0] face_sel_r;
  logic [CNT_W-1:0]  col_r, col_nxt;
  logic [CNT_W-1:0]  row_r, row_nxt;

  logic              x_side, y_side;
  logic [DIM_W-1:0]  fw, fh;
  logic signed [MW-1:0] w_s, h_s, c2p1, r2p1;
  logic signed [MW-1:0] mcx, mcy, mpx, mpy;
  logic              last_col, done, accept;

  function automatic logic [AM_W-1:0] mag(input logic signed [MW-1:0] m);
    logic signed [MW-1:0] a;
    a = (m < 0) ? -m : m;
    return a[AM_W-1:0];
  endfunction

  // configuration: always ready, a write restarts the face
  assign cfg_ch.ready = 1'b1;
  assign cfg_clr      = cfg_ch.valid;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign q_push      = accept;

  // face decode; unused codes act as front
  always_comb begin
    x_side = 1'b0;
    y_side = 1'b0;
    case (face_sel_r)
      FACE_TOP:    y_side = 1'b1;
      FACE_LEFT:   x_side = 1'b1;
      FACE_RIGHT:  x_side = 1'b1;
      FACE_BOTTOM: y_side = 1'b1;
      default:     ;
    endcase
  end

  assign fw   = x_side ? DIM_W'(FW4) : DIM_W'(FW2);
  assign fh   = y_side ? DIM_W'(FH4) : DIM_W'(FH2);
  assign w_s  = signed'(MW'(fw));
  assign h_s  = signed'(MW'(fh));
  assign c2p1 = signed'(MW'({col_r, 1'b1}));
  assign r2p1 = signed'(MW'({row_r, 1'b1}));

  // half-pixel offsets from the view direction and the patch normal
  always_comb begin
    mcx = w_s - c2p1;
    mpx = mcx;
    mcy = h_s - r2p1;
    mpy = mcy;
    case (face_sel_r)
      FACE_TOP: begin
        mcy = (h_s <<< 1) - r2p1;
        mpy = (h_s <<< 1) + r2p1;
      end
      FACE_LEFT: begin
        mcx = MW'(2) - c2p1;
        mpx = (w_s <<< 2) - c2p1;
      end
      FACE_RIGHT: begin
        mcx = (w_s <<< 1) - c2p1;
        mpx = (w_s <<< 1) + c2p1;
      end
      FACE_BOTTOM: begin
        mcy = MW'(2) - r2p1;
        mpy = (h_s <<< 2) - r2p1;
      end
      default: ;
    endcase
  end

  assign last_col = (DIM_W'(col_r) + DIM_W'(1)) >= fw;
  assign done     = last_col && ((DIM_W'(row_r) + DIM_W'(1)) >= fh);

  always_comb begin
    q_item.pix.red       = in_ch.red_in;
    q_item.pix.green     = in_ch.green_in;
    q_item.pix.blue      = in_ch.blue_in;
    q_item.pix.done      = done;
    q_item.am[LANE_CX]   = mag(mcx);
    q_item.am[LANE_CY]   = mag(mcy);
    q_item.am[LANE_PX]   = mag(mpx);
    q_item.am[LANE_PY]   = mag(mpy);
    q_item.x_side        = x_side;
    q_item.y_side        = y_side;
  end

  // raster position
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_clr) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      if (done) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (last_col) begin
        col_nxt = '0;
        row_nxt = row_r + CNT_W'(1);
      end else begin
        col_nxt = col_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      face_sel_r <= FACE_FRONT;
      col_r      <= '0;
      row_r      <= '0;
    end else begin
      if (cfg_clr) begin
        face_sel_r <= cfg_ch.face_select;
      end
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/hpw_queue.sv
// ----------------------------------------------------------------------------
// hpw_queue - two-entry queue between front and back
// Lets the front keep taking pixels while the back is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module hpw_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire hpw_pkg::hpw_item_t push_item,
  output      logic               full,
  input  wire logic               pop,
  output      logic               q_valid,
  output      hpw_pkg::hpw_item_t q_item
);
  import hpw_pkg::*;

  hpw_item_t          mem_r [0:QDEPTH-1];
  logic [QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]  cnt_r;
  logic               do_pop;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_item  = mem_r[rd_ptr_r];
  assign do_pop  = pop && q_valid;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push && !do_pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (do_pop && !push) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/hpw_back.sv
// ----------------------------------------------------------------------------
// hpw_back - weighting pipeline
// Offsets -> angles (reciprocal divide) -> cosines -> perspective and
// Lambert products -> weight -> weighted bytes and running face sums.
// ----------------------------------------------------------------------------
`default_nettype none

module hpw_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  input  wire hpw_pkg::hpw_item_t q_item,
  output      logic               q_pop,
  input  wire logic               cfg_clr,
  hpw_out_if.source               out_ch
);
  import hpw_pkg::*;

  // whole pipeline moves together when the output slot frees up
  logic adv;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, out_valid_r;
  hpw_pix_t pix1_r, pix2_r, pix3_r, pix4_r, pix5_r;

  logic [NLANES-1:0][NUM_W-1:0] num_r, num_nxt;
  logic [NLANES-1:0][RCP_W-1:0] rcp_r, rcp_nxt;
  logic [NLANES-1:0][ANG_W-1:0] ang_r, ang_nxt;
  logic [NLANES-1:0][COS_W-1:0] cos_r, cos_nxt;
  logic [COS_W-1:0] persp_r, persp_nxt, lamb_r, lamb_nxt;
  logic [COS_W-1:0] wt_r, wt_nxt;

  logic [BYTE_W-1:0] ro, go, bo;
  logic [SUM_W-1:0]  red_tot, green_tot, blue_tot;
  logic [SUM_W-1:0]  red_sum_r, green_sum_r, blue_sum_r;
  logic [BYTE_W-1:0] red_out_r, green_out_r, blue_out_r;
  logic              done_out_r;
  logic [SUM_W-1:0]  red_total_r, green_total_r, blue_total_r;

  function automatic logic [ANG_W-1:0] angle_of(input logic [NUM_W-1:0] num,
                                                input logic [RCP_W-1:0] rcp);
    logic [PROD_W-1:0] prod;
    logic [Q_W-1:0]    q;
    prod = PROD_W'(num) * PROD_W'(rcp);
    q    = prod[RCP_SHIFT +: Q_W];
    return (q >= Q_W'(ANG_MAX)) ? ANG_W'(ANG_MAX) : q[ANG_W-1:0];
  endfunction

  // linear interpolation between whole degrees
  function automatic logic [COS_W-1:0] cos_interp(input logic [ANG_W-1:0] a);
    logic [TAB_IW-1:0]    i;
    logic [5:0]           fr;
    logic [COS_W-1:0]     t0, t1, d;
    logic [COS_W+6:0]     corr;
    i    = a[ANG_W-1:6];
    fr   = a[5:0];
    t0   = COS_TAB[i];
    t1   = (i >= TAB_IW'(TAB_LAST)) ? t0 : COS_TAB[i + TAB_IW'(1)];
    d    = t0 - t1;
    corr = ((COS_W+7)'(d) * (COS_W+7)'(fr) + (COS_W+7)'(32)) >> 6;
    return t0 - corr[COS_W-1:0];
  endfunction

  function automatic logic [COS_W-1:0] qmul(input logic [COS_W-1:0] a,
                                            input logic [COS_W-1:0] b);
    logic [2*COS_W-1:0] p;
    p = (2*COS_W)'(a) * (2*COS_W)'(b);
    return p[FRAC +: COS_W];
  endfunction

  function automatic logic [BYTE_W-1:0] scale(input logic [BYTE_W-1:0] c,
                                              input logic [COS_W-1:0] w);
    logic [BYTE_W+COS_W-1:0] p;
    p = (BYTE_W+COS_W)'(c) * (BYTE_W+COS_W)'(w);
    return p[FRAC +: BYTE_W];
  endfunction

  assign adv   = !out_valid_r || out_ch.ready;
  assign q_pop = adv;

  // stage 1: numerator |m|*P*32 + f/2 and divisor reciprocal per lane
  always_comb begin
    for (int l = 0; l < NLANES; l++) begin
      if (l == LANE_CX || l == LANE_PX) begin
        num_nxt[l] = NUM_W'(q_item.am[l]) * (q_item.x_side ? PK45_N : PK90_N)
                   + (q_item.x_side ? HALF_FW4 : HALF_FW2);
        rcp_nxt[l] = q_item.x_side ? RCP_FW4 : RCP_FW2;
      end else begin
        num_nxt[l] = NUM_W'(q_item.am[l]) * (q_item.y_side ? PK45_N : PK90_N)
                   + (q_item.y_side ? HALF_FH4 : HALF_FH2);
        rcp_nxt[l] = q_item.y_side ? RCP_FH4 : RCP_FH2;
      end
    end
  end

  // stage 2: angle, stage 3: cosine
  always_comb begin
    for (int l = 0; l < NLANES; l++) begin
      ang_nxt[l] = angle_of(num_r[l], rcp_r[l]);
      cos_nxt[l] = cos_interp(ang_r[l]);
    end
  end

  // stage 4: perspective and Lambert terms, stage 5: weight
  assign persp_nxt = qmul(cos_r[LANE_CX], cos_r[LANE_CY]);
  assign lamb_nxt  = qmul(cos_r[LANE_PX], cos_r[LANE_PY]);
  assign wt_nxt    = qmul(persp_r, lamb_r);

  // stage 6: weighted bytes and running sums
  assign ro        = scale(pix5_r.red, wt_r);
  assign go        = scale(pix5_r.green, wt_r);
  assign bo        = scale(pix5_r.blue, wt_r);
  assign red_tot   = red_sum_r + SUM_W'(ro);
  assign green_tot = green_sum_r + SUM_W'(go);
  assign blue_tot  = blue_sum_r + SUM_W'(bo);

  // pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      pix1_r  <= q_item.pix;
      num_r   <= num_nxt;
      rcp_r   <= rcp_nxt;
      pix2_r  <= pix1_r;
      ang_r   <= ang_nxt;
      pix3_r  <= pix2_r;
      cos_r   <= cos_nxt;
      pix4_r  <= pix3_r;
      persp_r <= persp_nxt;
      lamb_r  <= lamb_nxt;
      pix5_r  <= pix4_r;
      wt_r    <= wt_nxt;
      if (v5_r) begin
        red_out_r     <= ro;
        green_out_r   <= go;
        blue_out_r    <= bo;
        done_out_r    <= pix5_r.done;
        red_total_r   <= red_tot;
        green_total_r <= green_tot;
        blue_total_r  <= blue_tot;
      end
    end
  end

  // stage valids and face sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
      red_sum_r   <= '0;
      green_sum_r <= '0;
      blue_sum_r  <= '0;
    end else begin
      if (adv) begin
        v1_r        <= q_valid;
        v2_r        <= v1_r;
        v3_r        <= v2_r;
        v4_r        <= v3_r;
        v5_r        <= v4_r;
        out_valid_r <= v5_r;
      end
      if (cfg_clr) begin
        red_sum_r   <= '0;
        green_sum_r <= '0;
        blue_sum_r  <= '0;
      end else if (adv && v5_r) begin
        red_sum_r   <= pix5_r.done ? '0 : red_tot;
        green_sum_r <= pix5_r.done ? '0 : green_tot;
        blue_sum_r  <= pix5_r.done ? '0 : blue_tot;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.red_out     = red_out_r;
  assign out_ch.green_out   = green_out_r;
  assign out_ch.blue_out    = blue_out_r;
  assign out_ch.face_done   = done_out_r;
  assign out_ch.red_total   = red_total_r;
  assign out_ch.green_total = green_total_r;
  assign out_ch.blue_total  = blue_total_r;

endmodule

`default_nettype wire

FILE: hdl/hemicube_pixel_weighting.sv
// ----------------------------------------------------------------------------
// hemicube_pixel_weighting - hemicube multiplier weighting of one face
// Usage:
//   cfg_ch : write face_select (0 front, 1 top, 2 left, 3 right, 4 bottom,
//            other codes act as front). Always ready. A write restarts the
//            face: column, row and the three running sums clear. Write only
//            while no pixel is in flight.
//   in_ch  : RGB pixels of the selected face in raster order, column fastest.
//   out_ch : one result per pixel: weighted bytes, face_done on the last
//            pixel of the face, and running per-face totals including it.
//            After the last pixel the next one starts a new pass.
// Timing: one pixel per cycle sustained while out_ch.ready stays high. An
//   accepted pixel passes the front queue, then five stages (angle
//   numerator, reciprocal divide, cosine lookup, cos products, weight),
//   then the output register.
// Stall: a result held by out_ch.ready low freezes the back pipeline; the
//   two-entry queue still takes up to two pixels, then in_ch.ready drops.
// Reset (rst_n, synchronous): face front, counters and sums zero, empty.
// ----------------------------------------------------------------------------
`default_nettype none

module hemicube_pixel_weighting (
  input  wire logic clk,
  input  wire logic rst_n,
  hpw_in_if.sink    in_ch,
  hpw_out_if.source out_ch,
  hpw_cfg_if.sink   cfg_ch
);
  import hpw_pkg::*;

  logic      q_full, q_push, q_valid, q_pop, cfg_clr;
  hpw_item_t push_item, pop_item;

  hpw_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .cfg_ch  (cfg_ch),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_item  (push_item),
    .cfg_clr (cfg_clr)
  );

  hpw_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_item    (pop_item)
  );

  hpw_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_item  (pop_item),
    .q_pop   (q_pop),
    .cfg_clr (cfg_clr),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

FILE: dv/hemicube_pixel_weighting_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hemicube_pixel_weighting_test - self-checking bench for the face weighting
// Streams RGB pixels through the block under every face code, with random
// source bursts and sink back-pressure. A scoreboard class tracks column,
// row and the running sums, predicts the cos-product weight per pixel and
// checks every result in order. The face code is rewritten between phases
// so the restart of the pass on a face write is exercised.
// ----------------------------------------------------------------------------

module hemicube_pixel_weighting_test;
  import hpw_pkg::*;

  // Run control
  localparam int CYCLE_LIMIT  = 4_000_000;  // several times the slowest legal run
  localparam int DRAIN_CYCLES = 20;         // longer than the result latency
  localparam int RANDOM_ITEMS = 950;

  // One expected or observed result
  typedef struct packed {
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic              done;
    logic [SUM_W-1:0]  red_sum;
    logic [SUM_W-1:0]  green_sum;
    logic [SUM_W-1:0]  blue_sum;
  } weighted_px_t;

  // --------------------------------------------------------------------------
  // Scoreboard: face geometry, cosine weighting and running per-face sums
  // --------------------------------------------------------------------------
  class face_weight_tracker;
    bit [COS_W-1:0]    cos_deg [0:90];
    bit [FACE_W-1:0]   face_code;
    bit [CNT_W-1:0]    col;
    bit [CNT_W-1:0]    row;
    bit [SUM_W-1:0]    red_acc;
    bit [SUM_W-1:0]    green_acc;
    bit [SUM_W-1:0]    blue_acc;
    weighted_px_t      weighted_due[$];
    int unsigned       mismatches;

    function new();
      build_cos_deg();
      face_code  = FACE_FRONT;
      mismatches = 0;
      clear_pass();
    endfunction

    // Q1.15 cos(k deg), Q30 Taylor series, 13 terms, rounded and clamped
    function void build_cos_deg();
      bit [63:0] x;
      bit [63:0] x2;
      bit [63:0] term;
      bit [63:0] v;
      longint    acc;
      for (int k = 0; k <= 90; k++) begin
        x    = (64'(k) * 64'd3373259426) / 64'd180;
        x2   = (x * x) >> 30;
        term = 64'd1 << 30;
        acc  = longint'(term);
        for (int n = 1; n <= 12; n++) begin
          term = (term * x2) >> 30;
          term = term / 64'((2 * n - 1) * (2 * n));
          if (n % 2 == 1) begin
            acc -= longint'(term);
          end else begin
            acc += longint'(term);
          end
        end
        if (acc < 0) begin
          acc = 0;
        end
        v = (64'(acc) + 64'd16384) >> 15;
        if (v > 64'd32768) begin
          v = 64'd32768;
        end
        cos_deg[k] = COS_W'(v);
      end
    endfunction

    // Linear interpolation between whole degrees, clamp at 90 degrees
    function int unsigned cos_of(int unsigned ang);
      int unsigned i;
      int unsigned f;
      int unsigned d;
      if (ang >= 90 * 64) begin
        return cos_deg[90];
      end
      i = ang >> 6;
      f = ang & 63;
      d = cos_deg[i] - cos_deg[i + 1];
      return cos_deg[i] - ((d * f + 32) >> 6);
    endfunction

    // |m| half-pixel steps of span/(2f) degrees, in 1/64 degree, rounded
    function int unsigned angle_of(int m, int unsigned span, int unsigned f);
      int unsigned am;
      am = (m < 0) ? -m : m;
      return (am * span * 32 + f / 2) / f;
    endfunction

    function void clear_pass();
      col       = '0;
      row       = '0;
      red_acc   = '0;
      green_acc = '0;
      blue_acc  = '0;
    endfunction

    function void set_face(bit [FACE_W-1:0] code);
      face_code = code;
      clear_pass();
    endfunction

    function int unsigned pending();
      return weighted_due.size();
    endfunction

    // Accepted pixel request: predict its result and advance the raster
    function void note_pixel(bit [BYTE_W-1:0] r, bit [BYTE_W-1:0] g, bit [BYTE_W-1:0] b);
      face_t        fc;
      int           fw;
      int           fh;
      int           c;
      int           rw;
      int           mcx;
      int           mcy;
      int           mpx;
      int           mpy;
      int unsigned  spx;
      int unsigned  spy;
      int unsigned  persp;
      int unsigned  lamb;
      int unsigned  wt;
      bit           last_col;
      weighted_px_t e;

      // codes above bottom weight as front
      fc = (face_code > FACE_BOTTOM) ? FACE_FRONT : face_t'(face_code);
      fw = (fc == FACE_LEFT || fc == FACE_RIGHT) ? FRAME_WIDTH / 4 : FRAME_WIDTH / 2;
      fh = (fc == FACE_TOP || fc == FACE_BOTTOM) ? FRAME_HEIGHT / 4 : FRAME_HEIGHT / 2;
      c  = int'(col);
      rw = int'(row);

      mcx = fw - (2 * c + 1);
      mpx = mcx;
      mcy = fh - (2 * rw + 1);
      mpy = mcy;
      spx = 90;
      spy = 90;
      case (fc)
        FACE_TOP: begin
          spy = 45;
          mcy = 2 * fh - (2 * rw + 1);
          mpy = 2 * fh + (2 * rw + 1);
        end
        FACE_LEFT: begin
          spx = 45;
          mcx = 1 - 2 * c;
          mpx = 4 * fw - (2 * c + 1);
        end
        FACE_RIGHT: begin
          spx = 45;
          mcx = 2 * fw - (2 * c + 1);
          mpx = 2 * fw + (2 * c + 1);
        end
        FACE_BOTTOM: begin
          spy = 45;
          mcy = 1 - 2 * rw;
          mpy = 4 * fh - (2 * rw + 1);
        end
        default: ;
      endcase

      // perspective and Lambert terms, then the combined weight
      persp = (cos_of(angle_of(mcx, spx, fw)) * cos_of(angle_of(mcy, spy, fh))) >> 15;
      lamb  = (cos_of(angle_of(mpx, spx, fw)) * cos_of(angle_of(mpy, spy, fh))) >> 15;
      wt    = (persp * lamb) >> 15;

      e.red   = BYTE_W'((int'(r) * wt) >> 15);
      e.green = BYTE_W'((int'(g) * wt) >> 15);
      e.blue  = BYTE_W'((int'(b) * wt) >> 15);

      red_acc   += e.red;
      green_acc += e.green;
      blue_acc  += e.blue;
      e.red_sum   = red_acc;
      e.green_sum = green_acc;
      e.blue_sum  = blue_acc;

      last_col = (c + 1 >= fw);
      e.done   = last_col && (rw + 1 >= fh);
      weighted_due.push_back(e);

      // raster advance; end of face starts a fresh pass
      if (e.done) begin
        clear_pass();
      end else if (last_col) begin
        col = '0;
        row = row + 1'b1;
      end else begin
        col = col + 1'b1;
      end
    endfunction

    function void check_field(string name, int unsigned want, int unsigned seen);
      if (want != seen) begin
        $error("%s: expected %0d, got %0d", name, want, seen);
        mismatches++;
      end
    endfunction

    // Accepted result: compare against the oldest prediction
    function void check_result(weighted_px_t got);
      weighted_px_t want;
      if (weighted_due.size() == 0) begin
        $error("result with no pixel outstanding: red_out %0d green_out %0d blue_out %0d",
               got.red, got.green, got.blue);
        mismatches++;
        return;
      end
      want = weighted_due.pop_front();
      check_field("red_out", want.red, got.red);
      check_field("green_out", want.green, got.green);
      check_field("blue_out", want.blue, got.blue);
      check_field("face_done", want.done, got.done);
      check_field("red_total", want.red_sum, got.red_sum);
      check_field("green_total", want.green_sum, got.green_sum);
      check_field("blue_total", want.blue_sum, got.blue_sum);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, channels and the block
  // --------------------------------------------------------------------------
  logic clk;
  logic rst_n;

  hpw_in_if  in_ch();
  hpw_out_if out_ch();
  hpw_cfg_if cfg_ch();

  hemicube_pixel_weighting dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  face_weight_tracker tracker;

  int unsigned cycle_count;
  int unsigned stall_pct;
  int unsigned stall_run_max;
  int unsigned stall_left;

  initial begin
    clk                = 1'b0;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.red_in       = '0;
    in_ch.green_in     = '0;
    in_ch.blue_in      = '0;
    out_ch.ready       = 1'b1;
    cfg_ch.valid       = 1'b0;
    cfg_ch.face_select = '0;
    cycle_count        = 0;
    stall_pct          = 0;
    stall_run_max      = 0;
    stall_left         = 0;
    tracker            = new();
  end

  always #6 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Sink back-pressure: ready held for random runs, stall share per phase
  always @(negedge clk) begin
    if (stall_left == 0) begin
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      stall_left = $urandom_range(0, stall_run_max);
    end else begin
      stall_left--;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    weighted_px_t seen;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen.red       = out_ch.red_out;
      seen.green     = out_ch.green_out;
      seen.blue      = out_ch.blue_out;
      seen.done      = out_ch.face_done;
      seen.red_sum   = out_ch.red_total;
      seen.green_sum = out_ch.green_total;
      seen.blue_sum  = out_ch.blue_total;
      tracker.check_result(seen);
    end
  end

  // --------------------------------------------------------------------------
  // Drivers: all called and returning at a falling edge
  // --------------------------------------------------------------------------
  function automatic bit [BYTE_W-1:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return BYTE_W'($urandom);
    endcase
  endfunction

  // One pixel request; valid stays high for a following request
  task automatic send_pixel(input bit [BYTE_W-1:0] r, input bit [BYTE_W-1:0] g,
                            input bit [BYTE_W-1:0] b);
    in_ch.valid    <= 1'b1;
    in_ch.red_in   <= r;
    in_ch.green_in <= g;
    in_ch.blue_in  <= b;
    do @(posedge clk); while (!in_ch.ready);
    tracker.note_pixel(r, g, b);
    @(negedge clk);
  endtask

  // Source gap with junk on the data lines
  task automatic idle_sender(input int unsigned n);
    in_ch.valid    <= 1'b0;
    in_ch.red_in   <= BYTE_W'($urandom);
    in_ch.green_in <= BYTE_W'($urandom);
    in_ch.blue_in  <= BYTE_W'($urandom);
    repeat (n) @(negedge clk);
  endtask

  // Random pixels in bursts, random gaps between bursts
  task automatic feed(input int unsigned count, input int unsigned max_gap,
                      input int unsigned max_burst);
    int unsigned burst;
    int unsigned gap;
    burst = 0;
    for (int unsigned i = 0; i < count; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, max_burst);
        if (max_gap > 0) begin
          gap = $urandom_range(0, max_gap);
          if (gap > 0) begin
            idle_sender(gap);
          end
        end
      end
      send_pixel(pick_byte(), pick_byte(), pick_byte());
      burst--;
    end
  endtask

  // Hold the source until every predicted result has come back
  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (tracker.pending() != 0);
  endtask

  // face_select write; only called with nothing in flight
  task automatic write_face(input bit [FACE_W-1:0] code);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.face_select <= code;
    do @(posedge clk); while (!cfg_ch.ready);
    tracker.set_face(code);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned sent;
    int unsigned phase;
    int unsigned n;
    int unsigned gap_max;

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset face, then every face code with extreme pixels
    send_pixel('1, '1, '1);
    send_pixel('0, '0, '0);
    wait_quiet();
    for (int f = 0; f < 8; f++) begin
      write_face(FACE_W'(f));
      send_pixel('1, '1, '1);
      send_pixel('0, '0, '0);
      send_pixel(8'hAA, 8'h55, 8'hFF);
      wait_quiet();
    end

    // random phases: face, source gaps and sink stalls vary per phase
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      write_face(FACE_W'($urandom_range(0, 7)));
      case (phase % 3)
        0: begin
          stall_pct     = 0;
          stall_run_max = 0;
          gap_max       = 0;
        end
        1: begin
          stall_pct     = 25;
          stall_run_max = 4;
          gap_max       = 3;
        end
        default: begin
          stall_pct     = 60;
          stall_run_max = 8;
          gap_max       = 12;
        end
      endcase
      n = $urandom_range(80, 160);
      if (phase == 2) begin
        // source holds mid-face until the pipeline is empty
        feed(n / 2, gap_max, 24);
        wait_quiet();
        feed(n - n / 2, gap_max, 24);
      end else begin
        feed(n, gap_max, 24);
      end
      wait_quiet();
      sent += n;
      phase++;
    end

    // catch stray results after the last expected one
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
